### rtl/sql_statement_grammar_checker_defines.svh
// ----------------------------------------------------------------------------
// sql statement grammar checker assertion macros
// shared property forms for the checker rtl
// ----------------------------------------------------------------------------
`ifndef SQL_STATEMENT_GRAMMAR_CHECKER_DEFINES_SVH
`define SQL_STATEMENT_GRAMMAR_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SQLGC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqlgc assertion failed");
`define SQLGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqlgc assertion failed");
`else
`define SQLGC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SQLGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/sqlgc_pkg.sv
// ----------------------------------------------------------------------------
// sqlgc_pkg
// types, codes and widths for the sql statement grammar checker
// ----------------------------------------------------------------------------
package sqlgc_pkg;

  localparam int MAX_FIELDS = 64;
  localparam int CNT_W      = $clog2(MAX_FIELDS + 1);
  localparam int TK_W       = 5;
  localparam int IDX_W      = 6;
  localparam int COUNT_W    = 7;

  localparam logic [TK_W-1:0] TK_ALTER    = 5'd0;
  localparam logic [TK_W-1:0] TK_CREATE   = 5'd1;
  localparam logic [TK_W-1:0] TK_DELETE   = 5'd2;
  localparam logic [TK_W-1:0] TK_INSERT   = 5'd3;
  localparam logic [TK_W-1:0] TK_SELECT   = 5'd4;
  localparam logic [TK_W-1:0] TK_IDENT    = 5'd5;
  localparam logic [TK_W-1:0] TK_LPAREN   = 5'd6;
  localparam logic [TK_W-1:0] TK_RPAREN   = 5'd7;
  localparam logic [TK_W-1:0] TK_COMMA    = 5'd8;
  localparam logic [TK_W-1:0] TK_INTO     = 5'd9;
  localparam logic [TK_W-1:0] TK_TYPE_INT = 5'd10;
  localparam logic [TK_W-1:0] TK_TYPE_STR = 5'd12;
  localparam logic [TK_W-1:0] TK_LIT_INT  = 5'd13;
  localparam logic [TK_W-1:0] TK_LIT_STR  = 5'd15;

  typedef enum logic [3:0] {
    G_START, G_C_TABLE, G_C_LPAREN, G_C_FIRST, G_C_TYPE, G_C_SEP, G_C_NAME,
    G_DONE, G_D_TABLE, G_I_LPAREN, G_I_VAL, G_I_SEP, G_I_INTO, G_I_TABLE, G_ANY
  } gpos_t;

  typedef enum logic [2:0] {
    K_NONE, K_ALTER, K_CREATE, K_DELETE, K_INSERT, K_SELECT
  } kind_t;

  typedef enum logic [2:0] {
    R_SYNTAX, R_TABLE, R_FNAME, R_FTYPE, R_VALUE, R_IGNORED
  } role_t;

  typedef enum logic [1:0] {
    ST_FINE, ST_ERROR, ST_ACCEPT, ST_REJECT
  } status_t;

  typedef struct packed {
    status_t            status;
    kind_t              kind;
    role_t              role;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

### rtl/sql_statement_grammar_checker.sv
// ----------------------------------------------------------------------------
// sql_statement_grammar_checker
// path: an accepted item is held in stage s1, then its result in res_r on the out_ port
// throughput: one item per cycle while the output is not stalled
// stall on the output holds both stages; in_stall rises once both are full and out_stall is high
// reset (rst_n low, synchronous) clears grammar state and both valid stages
// ----------------------------------------------------------------------------
`include "sql_statement_grammar_checker_defines.svh"

module sql_statement_grammar_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [sqlgc_pkg::TK_W-1:0]     in_token_class,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [2:0]                     out_statement_kind,
  output logic [2:0]                     out_token_role,
  output logic [sqlgc_pkg::IDX_W-1:0]    out_field_index,
  output logic [sqlgc_pkg::COUNT_W-1:0]  out_field_count
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_op_r;
  logic [sqlgc_pkg::TK_W-1:0]    s1_tk_r;
  logic                          out_valid_r, out_valid_nxt;
  sqlgc_pkg::res_t               res;
  sqlgc_pkg::res_t               res_r;
  logic                          adv;
  logic                          step_en;
  logic                          s1_load;

  assign adv     = !out_valid_r || !out_stall;
  assign step_en = s1_valid_r && adv;
  assign s1_load = !s1_valid_r || adv;
  assign in_stall = !s1_load;

  assign s1_valid_nxt  = s1_load ? in_valid : s1_valid_r;
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  sqlgc_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .op      (s1_op_r),
    .tk      (s1_tk_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_op_r <= in_op;
      s1_tk_r <= in_token_class;
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_statement_kind = res_r.kind;
  assign out_token_role     = res_r.role;
  assign out_field_index    = res_r.idx;
  assign out_field_count    = res_r.count;

  `SQLGC_ASSERT_NEXT(a_step_loads_out, clk, rst_n, step_en, out_valid_r)
  `SQLGC_ASSERT_IMPLY(a_no_drop, clk, rst_n, out_valid_r && out_stall,
    !step_en && (in_stall || !s1_valid_r))
  `SQLGC_ASSERT_NEXT(a_hold_s1, clk, rst_n, s1_valid_r && !adv, s1_valid_r)

endmodule

### rtl/sqlgc_fsm.sv
// ----------------------------------------------------------------------------
// sqlgc_fsm
// grammar position, statement kind, field count and sticky error; one item
// per enabled cycle, producing its result fields
// ----------------------------------------------------------------------------
`include "sql_statement_grammar_checker_defines.svh"

module sqlgc_fsm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic                        op,
  input  logic [sqlgc_pkg::TK_W-1:0]  tk,
  output sqlgc_pkg::res_t             res
);

  sqlgc_pkg::gpos_t                pos_r, pos_nxt;
  sqlgc_pkg::kind_t                kind_r, kind_nxt;
  logic [sqlgc_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            err_r, err_nxt;
  logic                            room;
  logic                            is_type;
  logic                            is_lit;

  assign room    = cnt_r < sqlgc_pkg::CNT_W'(sqlgc_pkg::MAX_FIELDS);
  assign is_type = (tk >= sqlgc_pkg::TK_TYPE_INT) && (tk <= sqlgc_pkg::TK_TYPE_STR);
  assign is_lit  = (tk >= sqlgc_pkg::TK_LIT_INT) && (tk <= sqlgc_pkg::TK_LIT_STR);

  // next state
  always_comb begin
    logic bad;
    bad      = 1'b0;
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    if (op) begin
      pos_nxt  = sqlgc_pkg::G_START;
      kind_nxt = sqlgc_pkg::K_NONE;
      cnt_nxt  = '0;
      err_nxt  = 1'b0;
    end else if (!err_r) begin
      unique case (pos_r)
        sqlgc_pkg::G_START: begin
          priority if (tk == sqlgc_pkg::TK_ALTER) begin
            kind_nxt = sqlgc_pkg::K_ALTER;
            pos_nxt  = sqlgc_pkg::G_ANY;
          end else if (tk == sqlgc_pkg::TK_CREATE) begin
            kind_nxt = sqlgc_pkg::K_CREATE;
            pos_nxt  = sqlgc_pkg::G_C_TABLE;
          end else if (tk == sqlgc_pkg::TK_DELETE) begin
            kind_nxt = sqlgc_pkg::K_DELETE;
            pos_nxt  = sqlgc_pkg::G_D_TABLE;
          end else if (tk == sqlgc_pkg::TK_INSERT) begin
            kind_nxt = sqlgc_pkg::K_INSERT;
            pos_nxt  = sqlgc_pkg::G_I_LPAREN;
          end else if (tk == sqlgc_pkg::TK_SELECT) begin
            kind_nxt = sqlgc_pkg::K_SELECT;
            pos_nxt  = sqlgc_pkg::G_ANY;
          end else begin
            bad = 1'b1;
          end
        end
        sqlgc_pkg::G_C_TABLE: begin
          if (tk == sqlgc_pkg::TK_IDENT) pos_nxt = sqlgc_pkg::G_C_LPAREN;
          else bad = 1'b1;
        end
        sqlgc_pkg::G_D_TABLE, sqlgc_pkg::G_I_TABLE: begin
          if (tk == sqlgc_pkg::TK_IDENT) pos_nxt = sqlgc_pkg::G_DONE;
          else bad = 1'b1;
        end
        sqlgc_pkg::G_C_LPAREN: begin
          if (tk == sqlgc_pkg::TK_LPAREN) pos_nxt = sqlgc_pkg::G_C_FIRST;
          else bad = 1'b1;
        end
        sqlgc_pkg::G_I_LPAREN: begin
          if (tk == sqlgc_pkg::TK_LPAREN) pos_nxt = sqlgc_pkg::G_I_VAL;
          else bad = 1'b1;
        end
        sqlgc_pkg::G_C_FIRST, sqlgc_pkg::G_C_NAME: begin
          priority if (tk == sqlgc_pkg::TK_RPAREN && pos_r == sqlgc_pkg::G_C_FIRST) begin
            pos_nxt = sqlgc_pkg::G_DONE;
          end else if (tk == sqlgc_pkg::TK_IDENT && room) begin
            pos_nxt = sqlgc_pkg::G_C_TYPE;
          end else begin
            bad = 1'b1;
          end
        end
        sqlgc_pkg::G_C_TYPE: begin
          if (is_type) begin
            cnt_nxt = cnt_r + 1'b1;
            pos_nxt = sqlgc_pkg::G_C_SEP;
          end else begin
            bad = 1'b1;
          end
        end
        sqlgc_pkg::G_C_SEP: begin
          priority if (tk == sqlgc_pkg::TK_COMMA) pos_nxt = sqlgc_pkg::G_C_NAME;
          else if (tk == sqlgc_pkg::TK_RPAREN) pos_nxt = sqlgc_pkg::G_DONE;
          else bad = 1'b1;
        end
        sqlgc_pkg::G_I_VAL: begin
          if (is_lit && room) begin
            cnt_nxt = cnt_r + 1'b1;
            pos_nxt = sqlgc_pkg::G_I_SEP;
          end else begin
            bad = 1'b1;
          end
        end
        sqlgc_pkg::G_I_SEP: begin
          priority if (tk == sqlgc_pkg::TK_COMMA) pos_nxt = sqlgc_pkg::G_I_VAL;
          else if (tk == sqlgc_pkg::TK_RPAREN) pos_nxt = sqlgc_pkg::G_I_INTO;
          else bad = 1'b1;
        end
        sqlgc_pkg::G_I_INTO: begin
          if (tk == sqlgc_pkg::TK_INTO) pos_nxt = sqlgc_pkg::G_I_TABLE;
          else bad = 1'b1;
        end
        sqlgc_pkg::G_ANY: begin
          pos_nxt = sqlgc_pkg::G_ANY;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        err_nxt  = 1'b1;
        pos_nxt  = pos_r;
        kind_nxt = kind_r;
        cnt_nxt  = cnt_r;
      end
    end
  end

  // result fields
  always_comb begin
    sqlgc_pkg::role_t role;
    logic             ok;
    role = sqlgc_pkg::R_SYNTAX;
    ok   = !err_r && (pos_r == sqlgc_pkg::G_START || pos_r == sqlgc_pkg::G_DONE ||
                      pos_r == sqlgc_pkg::G_ANY);
    unique case (pos_r)
      sqlgc_pkg::G_C_TABLE, sqlgc_pkg::G_D_TABLE, sqlgc_pkg::G_I_TABLE:
        role = sqlgc_pkg::R_TABLE;
      sqlgc_pkg::G_C_FIRST, sqlgc_pkg::G_C_NAME: begin
        if (tk == sqlgc_pkg::TK_IDENT) role = sqlgc_pkg::R_FNAME;
      end
      sqlgc_pkg::G_C_TYPE: role = sqlgc_pkg::R_FTYPE;
      sqlgc_pkg::G_I_VAL:  role = sqlgc_pkg::R_VALUE;
      sqlgc_pkg::G_ANY:    role = sqlgc_pkg::R_IGNORED;
      default:             role = sqlgc_pkg::R_SYNTAX;
    endcase
    res.kind = kind_r;
    if (op) begin
      res.status = ok ? sqlgc_pkg::ST_ACCEPT : sqlgc_pkg::ST_REJECT;
      res.role   = sqlgc_pkg::R_SYNTAX;
      res.idx    = '0;
      res.count  = sqlgc_pkg::COUNT_W'(cnt_r);
    end else if (err_nxt) begin
      res.status = sqlgc_pkg::ST_ERROR;
      res.kind   = kind_nxt;
      res.role   = sqlgc_pkg::R_IGNORED;
      res.idx    = '0;
      res.count  = sqlgc_pkg::COUNT_W'(cnt_nxt);
    end else begin
      res.status = sqlgc_pkg::ST_FINE;
      res.kind   = kind_nxt;
      res.role   = role;
      res.idx    = (role == sqlgc_pkg::R_FNAME || role == sqlgc_pkg::R_FTYPE ||
                    role == sqlgc_pkg::R_VALUE) ? sqlgc_pkg::IDX_W'(cnt_r) : '0;
      res.count  = sqlgc_pkg::COUNT_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= sqlgc_pkg::G_START;
      kind_r <= sqlgc_pkg::K_NONE;
      cnt_r  <= '0;
      err_r  <= 1'b0;
    end else if (step_en) begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
    end
  end

  `SQLGC_ASSERT_NEXT(a_end_clears, clk, rst_n, step_en && op,
    pos_r == sqlgc_pkg::G_START && cnt_r == '0 && !err_r && kind_r == sqlgc_pkg::K_NONE)
  `SQLGC_ASSERT_NEXT(a_err_sticky, clk, rst_n, step_en && !op && err_r, err_r)
  `SQLGC_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1,
    cnt_r <= sqlgc_pkg::CNT_W'(sqlgc_pkg::MAX_FIELDS))
  `SQLGC_ASSERT_IMPLY(a_err_role, clk, rst_n, step_en && !op && err_r,
    res.role == sqlgc_pkg::R_IGNORED && res.idx == '0 &&
    res.status == sqlgc_pkg::ST_ERROR)

endmodule
